FILE: sv/disk_request_scheduler_unit_assert.svh
// Assertion macros for the disk request scheduler
`ifndef DISK_REQUEST_SCHEDULER_UNIT_ASSERT_SVH
`define DISK_REQUEST_SCHEDULER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DRS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define DRS_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DRS_ASSERT(label, clk, rst_n, prop)
`define DRS_ASSERT_NR(label, clk, prop)
`endif
`endif

FILE: sv/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg
// Shared codes for the disk request scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package drs_pkg;
  localparam logic [1:0] MODE_ENQ  = 2'd0;
  localparam logic [1:0] MODE_DISP = 2'd1;
  localparam logic [1:0] MODE_CPL  = 2'd2;
  localparam logic [1:0] POL_FCFS  = 2'd0;
  localparam logic [1:0] POL_SSTF  = 2'd1;
  localparam logic [1:0] POL_CSCAN = 2'd2;
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_EMPTY  = 3'd2;
  localparam logic [2:0] ST_BUSY   = 3'd3;
  localparam logic [2:0] ST_NOEXEC = 3'd4;
  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_DISK   = 1'b1;
endpackage
`default_nettype wire

FILE: sv/drs_stream_if.sv
// ----------------------------------------------------------------------------
// drs_stream_if
// Valid/ready channel carrying a packed payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface drs_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/drs_front.sv
// ----------------------------------------------------------------------------
// drs_front
// Accepts input items into a two-entry command queue.
// ----------------------------------------------------------------------------
`default_nettype none
module drs_front #(
  parameter int W = 28
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [W-1:0] in_data_i,
  output logic              cmd_valid_o,
  input  wire logic         cmd_ready_i,
  output logic [W-1:0]      cmd_data_o
);
  logic [W-1:0] mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;
  logic         push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_data_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: sv/drs_back.sv
// ----------------------------------------------------------------------------
// drs_back
// Executes commands: queue storage, selection scan, completion accounting.
// ----------------------------------------------------------------------------
`default_nettype none
`include "disk_request_scheduler_unit_assert.svh"
module drs_back #(
  parameter int QUEUE_DEPTH = 16,
  parameter int BLOCK_BITS  = 16,
  parameter int TAG_BITS    = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [1:0]            policy_i,
  input  wire logic [16:0]           disk_blocks_i,
  input  wire logic                  cmd_valid_i,
  output logic                       cmd_ready_o,
  input  wire logic [1:0]            mode_i,
  input  wire logic [BLOCK_BITS-1:0] blk_i,
  input  wire logic [TAG_BITS-1:0]   tag_i,
  input  wire logic                  wr_i,
  input  wire logic                  failed_i,
  output logic                       res_valid_o,
  input  wire logic                  res_ready_i,
  output logic [2:0]                 status_o,
  output logic                       dv_o,
  output logic [BLOCK_BITS-1:0]      db_o,
  output logic [TAG_BITS-1:0]        dt_o,
  output logic                       dw_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] count_o,
  output logic [BLOCK_BITS-1:0]      head_o,
  output logic [31:0]                total_o
);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH+1);
  // signed distance: C-SCAN can stay negative when blocks lie beyond the disk
  localparam int DW = (BLOCK_BITS > 17 ? BLOCK_BITS : 17) + 2;
  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_RD = 3'd2,
                         S_SHIFT = 3'd3, S_OUT = 3'd4;

  logic [BLOCK_BITS-1:0] eb_q [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]   et_q [QUEUE_DEPTH];
  logic                  ew_q [QUEUE_DEPTH];
  logic [2:0]   st_q;
  logic [CW-1:0] cnt_q;
  logic [BLOCK_BITS-1:0] head_q, xb_q;
  logic [TAG_BITS-1:0]   xt_q;
  logic          xv_q;
  logic [31:0]   tot_q;
  logic [IW-1:0] i_q, best_q;
  logic [DW-1:0] bd_q;
  logic [BLOCK_BITS-1:0] rb_q;
  logic [TAG_BITS-1:0]   rt_q;
  logic                  rw_q;
  logic [DW-1:0] d_cur;
  logic          better;
  logic [BLOCK_BITS-1:0] e_cur;
  logic [32:0]   sum;
  logic [BLOCK_BITS-1:0] seek_dist;
  logic          take;

  assign cmd_ready_o = st_q == S_IDLE;
  assign res_valid_o = st_q == S_OUT;
  assign count_o = cnt_q;
  assign head_o  = head_q;
  assign total_o = tot_q;
  assign take = cmd_valid_i && cmd_ready_o;
  assign e_cur = eb_q[i_q];

  always_comb begin
    d_cur = '0;
    better = 1'b0;
    if (policy_i == drs_pkg::POL_SSTF) begin
      d_cur = (e_cur >= head_q) ? DW'(e_cur - head_q) : DW'(head_q - e_cur);
      better = (i_q == '0) || ($signed(d_cur) < $signed(bd_q));
    end else if (policy_i == drs_pkg::POL_CSCAN) begin
      d_cur = (e_cur >= head_q) ? DW'(e_cur) - DW'(head_q)
                                : DW'(e_cur) + DW'(disk_blocks_i) - DW'(head_q);
      // bd_q starts at the disk size, so nothing past it wins
      better = $signed(d_cur) < $signed(bd_q);
    end
  end

  assign seek_dist = (head_q >= xb_q) ? head_q - xb_q : xb_q - head_q;
  assign sum  = {1'b0, tot_q} + 33'(seek_dist);

  always_ff @(posedge clk_i) begin
    if (take && mode_i == drs_pkg::MODE_ENQ && cnt_q < CW'(QUEUE_DEPTH)) begin
      eb_q[cnt_q[IW-1:0]] <= blk_i;
      et_q[cnt_q[IW-1:0]] <= tag_i;
      ew_q[cnt_q[IW-1:0]] <= wr_i;
    end
    if (st_q == S_SHIFT && CW'(i_q) + 1'b1 < cnt_q) begin
      eb_q[i_q] <= eb_q[i_q + 1'b1];
      et_q[i_q] <= et_q[i_q + 1'b1];
      ew_q[i_q] <= ew_q[i_q + 1'b1];
    end
    if (st_q == S_RD) begin
      rb_q <= eb_q[best_q];
      rt_q <= et_q[best_q];
      rw_q <= ew_q[best_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0; head_q <= '0; tot_q <= '0;
      xv_q <= 1'b0; xb_q <= '0; xt_q <= '0; i_q <= '0; best_q <= '0;
      bd_q <= '0; status_o <= '0; dv_o <= 1'b0; db_o <= '0; dt_o <= '0;
      dw_o <= 1'b0;
    end else begin
      unique case (st_q)
        S_IDLE: if (take) begin
          status_o <= drs_pkg::ST_OK; dv_o <= 1'b0; db_o <= '0;
          dt_o <= '0; dw_o <= 1'b0;
          st_q <= S_OUT;
          if (mode_i == drs_pkg::MODE_ENQ) begin
            if (cnt_q >= CW'(QUEUE_DEPTH)) status_o <= drs_pkg::ST_FULL;
            else cnt_q <= cnt_q + 1'b1;
          end else if (mode_i == drs_pkg::MODE_DISP) begin
            if (xv_q) status_o <= drs_pkg::ST_BUSY;
            else if (cnt_q == '0) status_o <= drs_pkg::ST_EMPTY;
            else begin
              i_q <= '0; best_q <= '0; bd_q <= DW'(disk_blocks_i); st_q <= S_SCAN;
            end
          end else if (mode_i == drs_pkg::MODE_CPL) begin
            if (!xv_q) status_o <= drs_pkg::ST_NOEXEC;
            else begin
              dt_o <= xt_q;
              xv_q <= 1'b0;
              if (!failed_i) begin
                tot_q <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                head_q <= xb_q;
              end
            end
          end
        end
        S_SCAN: begin
          if (better) begin
            best_q <= i_q; bd_q <= d_cur;
          end
          if (policy_i != drs_pkg::POL_SSTF && policy_i != drs_pkg::POL_CSCAN ||
              CW'(i_q) + 1'b1 >= cnt_q) st_q <= S_RD;
          else i_q <= i_q + 1'b1;
        end
        S_RD: begin
          i_q <= best_q; st_q <= S_SHIFT;
          dv_o <= 1'b1;
        end
        S_SHIFT: begin
          if (i_q == best_q) begin
            db_o <= rb_q; dt_o <= rt_q; dw_o <= rw_q;
            xv_q <= 1'b1; xb_q <= rb_q; xt_q <= rt_q;
          end
          if (CW'(i_q) + 1'b1 >= cnt_q) begin
            cnt_q <= cnt_q - 1'b1; st_q <= S_OUT;
          end else i_q <= i_q + 1'b1;
        end
        S_OUT: if (res_ready_i) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  `DRS_ASSERT(a_cnt_le, clk_i, rst_ni, cnt_q <= CW'(QUEUE_DEPTH))
  `DRS_ASSERT(a_out_hold, clk_i, rst_ni, res_valid_o && !res_ready_i |=> res_valid_o)
  `DRS_ASSERT(a_disp_exec, clk_i, rst_ni, res_valid_o && dv_o |-> xv_q)
endmodule
`default_nettype wire

FILE: sv/disk_request_scheduler_unit.sv
// Enqueue and complete go from idle straight to the result; dispatch first
// scans the queue (only the head entry under FCFS), reads the chosen entry and
// compacts the entry registers behind it. Throughput: one item at a time in
// the back end; the front queue takes two items ahead. Reset clears counts,
// head, total and the executing slot; queue entries are not cleared.
// ----------------------------------------------------------------------------
// disk_request_scheduler_unit
// Disk request queue with FCFS, SSTF and C-SCAN dispatch.
// ----------------------------------------------------------------------------
`default_nettype none
module disk_request_scheduler_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int BLOCK_BITS  = 16,
  parameter int TAG_BITS    = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [16:0] cfg_data_i,
  drs_stream_if.sink       in_if,
  drs_stream_if.source     out_if
);
  localparam int IW = 2 + BLOCK_BITS + TAG_BITS + 2;
  localparam int CW = $clog2(QUEUE_DEPTH+1);
  logic [1:0]  policy_q;
  logic [16:0] disk_q;
  logic        cv, cr;
  logic [IW-1:0] cd;
  logic [2:0] st; logic dv, dw;
  logic [BLOCK_BITS-1:0] db, hd; logic [TAG_BITS-1:0] dt;
  logic [CW-1:0] cnt; logic [31:0] tot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= drs_pkg::POL_FCFS; disk_q <= 17'h10000;
    end else if (cfg_we_i) begin
      if (cfg_index_i == drs_pkg::CFG_POLICY) policy_q <= cfg_data_i[1:0];
      else disk_q <= cfg_data_i;
    end
  end

  drs_front #(.W(IW)) u_front (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .in_data_i(in_if.data), .cmd_valid_o(cv), .cmd_ready_i(cr), .cmd_data_o(cd)
  );

  drs_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .BLOCK_BITS(BLOCK_BITS),
             .TAG_BITS(TAG_BITS)) u_back (
    .clk_i, .rst_ni, .policy_i(policy_q), .disk_blocks_i(disk_q),
    .cmd_valid_i(cv), .cmd_ready_o(cr), .mode_i(cd[IW-1 -: 2]),
    .blk_i(cd[IW-3 -: BLOCK_BITS]), .tag_i(cd[TAG_BITS+1:2]), .wr_i(cd[1]),
    .failed_i(cd[0]), .res_valid_o(out_if.valid), .res_ready_i(out_if.ready),
    .status_o(st), .dv_o(dv), .db_o(db), .dt_o(dt), .dw_o(dw), .count_o(cnt),
    .head_o(hd), .total_o(tot)
  );

  assign out_if.data = {st, dv, db, dt, dw, cnt, hd, tot};
endmodule
`default_nettype wire

FILE: tb/disk_request_scheduler_unit_test.sv
// ----------------------------------------------------------------------------
// disk_request_scheduler_unit_test
// Drives enqueue, dispatch and complete requests under all dispatch policies
// and several disk sizes, predicts every result in the testbench and compares each
// result transfer field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none
module disk_request_scheduler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int QDEPTH = 16;
  // worst dispatch covers a full queue scan and compaction, plus margin
  localparam int SETTLE_CYCLES = 3 + 2 * QDEPTH + 8;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] blk;
    logic [7:0]  tag;
    logic        wr;
    logic        failed;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        dv;
    logic [15:0] dblk;
    logic [7:0]  dtag;
    logic        dwr;
    logic [4:0]  count;
    logic [15:0] head;
    logic [31:0] travelled;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [16:0] cfg_data_i = '0;

  drs_stream_if #(.W($bits(req_t))) in_ch ();
  drs_stream_if #(.W($bits(rsp_t))) out_ch ();

  disk_request_scheduler_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch.sink),
    .out_if     (out_ch.source)
  );

  // scheduler shadow state
  logic [1:0]  pol_q;
  logic [16:0] disk_q;
  logic [15:0] ent_blk [QDEPTH];
  logic [7:0]  ent_tag [QDEPTH];
  logic        ent_wr [QDEPTH];
  int          pend_q;
  logic [15:0] head_q;
  logic [31:0] seek_q;
  logic        busy_q;
  logic [15:0] busy_blk;
  logic [7:0]  busy_tag;

  rsp_t pending_rsp [$];
  int   mismatches = 0;
  int   hold_left = 0;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic int choose_slot();
    int best;
    longint bd, d;
    best = 0;
    if (pol_q == drs_pkg::POL_SSTF) begin
      bd = (ent_blk[0] > head_q) ? ent_blk[0] - head_q : head_q - ent_blk[0];
      for (int i = 1; i < pend_q; i++) begin
        d = (ent_blk[i] > head_q) ? ent_blk[i] - head_q : head_q - ent_blk[i];
        if (d < bd) begin
          bd = d;
          best = i;
        end
      end
    end else if (pol_q == drs_pkg::POL_CSCAN) begin
      bd = disk_q;
      for (int i = 0; i < pend_q; i++) begin
        d = longint'(ent_blk[i]) - longint'(head_q);
        if (d < 0) d += disk_q;
        if (d < bd) begin
          bd = d;
          best = i;
        end
      end
    end
    return best;
  endfunction

  task automatic schedule_step(input req_t r, output rsp_t o);
    int k;
    longint sum;
    o = '0;
    case (r.mode)
      drs_pkg::MODE_ENQ: begin
        if (pend_q >= QDEPTH) begin
          o.status = drs_pkg::ST_FULL;
        end else begin
          ent_blk[pend_q] = r.blk;
          ent_tag[pend_q] = r.tag;
          ent_wr[pend_q] = r.wr;
          pend_q++;
        end
      end
      drs_pkg::MODE_DISP: begin
        if (busy_q) begin
          o.status = drs_pkg::ST_BUSY;
        end else if (pend_q == 0) begin
          o.status = drs_pkg::ST_EMPTY;
        end else begin
          k = choose_slot();
          o.dv = 1'b1;
          o.dblk = ent_blk[k];
          o.dtag = ent_tag[k];
          o.dwr = ent_wr[k];
          for (int i = k; i + 1 < pend_q; i++) begin
            ent_blk[i] = ent_blk[i+1];
            ent_tag[i] = ent_tag[i+1];
            ent_wr[i] = ent_wr[i+1];
          end
          pend_q--;
          busy_q = 1'b1;
          busy_blk = o.dblk;
          busy_tag = o.dtag;
        end
      end
      drs_pkg::MODE_CPL: begin
        if (!busy_q) begin
          o.status = drs_pkg::ST_NOEXEC;
        end else begin
          o.dtag = busy_tag;
          if (!r.failed) begin
            sum = longint'(seek_q) +
                  ((head_q > busy_blk) ? head_q - busy_blk : busy_blk - head_q);
            seek_q = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            head_q = busy_blk;
          end
          busy_q = 1'b0;
        end
      end
      default: ;
    endcase
    o.count = pend_q[4:0];
    o.head = head_q;
    o.travelled = seek_q;
  endtask

  // entered and left at a rising edge; valid stays up across back-to-back items
  task automatic send_req(input req_t r, input int gap);
    rsp_t o;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    do @(negedge clk_i); while (!in_ch.ready);
    schedule_step(r, o);
    pending_rsp.push_back(o);
    @(posedge clk_i);
  endtask

  task automatic send(input logic [1:0] m, input logic [15:0] b, input logic [7:0] t,
                      input logic w, input logic f, input int gap);
    req_t r;
    r = '{mode: m, blk: b, tag: t, wr: w, failed: f};
    send_req(r, gap);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [16:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == drs_pkg::CFG_POLICY) pol_q = val[1:0];
    else disk_q = val;
  endtask

  // receiver side: random stalls, plus an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) < 70);
    end
  end

  function automatic void check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s expected %0d actual %0d", name, e, a);
      mismatches++;
    end
  endfunction

  always @(negedge clk_i) begin
    rsp_t e, a;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (pending_rsp.size() == 0) begin
        $error("unexpected result transfer status %0d", a.status);
        mismatches++;
      end else begin
        e = pending_rsp.pop_front();
        check_field("status", e.status, a.status);
        check_field("dispatched_valid", e.dv, a.dv);
        check_field("dispatched_block", e.dblk, a.dblk);
        check_field("dispatched_tag", e.dtag, a.dtag);
        check_field("dispatched_write", e.dwr, a.dwr);
        check_field("queue_count", e.count, a.count);
        check_field("head_block", e.head, a.head);
        check_field("blocks_travelled", e.travelled, a.travelled);
      end
    end
  end

  int idle_cycles = 0;
  always @(negedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic test_field_extremes();
    send(drs_pkg::MODE_ENQ, 16'h0000, 8'h00, 1'b0, 1'b0, 0);
    send(drs_pkg::MODE_ENQ, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 0);
    send(drs_pkg::MODE_DISP, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 0);
    send(drs_pkg::MODE_CPL, 16'h0, 8'h0, 1'b0, 1'b0, 0);
    send(drs_pkg::MODE_DISP, 16'h0, 8'h0, 1'b0, 1'b0, 0);
    send(drs_pkg::MODE_CPL, 16'h0, 8'h0, 1'b0, 1'b0, 1);
    send(MODE_NOP, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 0);
    drain();
  endtask

  task automatic test_status_cases();
    send(drs_pkg::MODE_DISP, 16'h0, 8'h0, 1'b0, 1'b0, 0);  // empty
    send(drs_pkg::MODE_CPL, 16'h0, 8'h0, 1'b0, 1'b0, 0);   // nothing executing
    for (int i = 0; i < QDEPTH + 1; i++)                   // last one is full
      send(drs_pkg::MODE_ENQ, 16'($urandom), 8'($urandom), 1'($urandom), 1'b0, 0);
    send(drs_pkg::MODE_DISP, 16'h0, 8'h0, 1'b0, 1'b0, 0);
    send(drs_pkg::MODE_DISP, 16'h0, 8'h0, 1'b0, 1'b0, 0);  // busy
    send(drs_pkg::MODE_CPL, 16'h0, 8'h0, 1'b0, 1'b0, 0);
    drain();
  endtask

  task automatic empty_queue();
    while (pend_q > 0 || busy_q) begin
      if (busy_q) send(drs_pkg::MODE_CPL, 16'h0, 8'h0, 1'b0, 1'b0, 0);
      send(drs_pkg::MODE_DISP, 16'h0, 8'h0, 1'b0, 1'b0, 0);
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_left = 300;
    for (int i = 0; i < 12; i++)
      send(drs_pkg::MODE_ENQ, 16'($urandom), 8'($urandom), 1'($urandom), 1'b0, 0);
    drain();
    empty_queue();
  endtask

  task automatic random_phase(input logic [1:0] pol, input logic [16:0] disk, input int n);
    int r;
    logic [15:0] b;
    write_cfg(drs_pkg::CFG_POLICY, {15'd0, pol});
    write_cfg(drs_pkg::CFG_DISK, disk);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      b = ($urandom_range(9) < 8 && disk <= 17'd65535) ?
          16'($urandom_range(disk - 1)) : 16'($urandom);
      if (r < 45) send(drs_pkg::MODE_ENQ, b, 8'($urandom), 1'($urandom), 1'b0,
                       pick_gap());
      else if (r < 70) send(drs_pkg::MODE_DISP, 16'($urandom), 8'($urandom),
                            1'($urandom), 1'($urandom), pick_gap());
      else if (r < 95) send(drs_pkg::MODE_CPL, 16'($urandom), 8'($urandom),
                            1'($urandom), ($urandom_range(9) == 0), pick_gap());
      else send(MODE_NOP, 16'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                pick_gap());
    end
    drain();
  endtask

  task automatic test_random_policies();
    random_phase(drs_pkg::POL_FCFS, 17'd65536, 250);
    random_phase(drs_pkg::POL_SSTF, 17'd65536, 250);
    random_phase(drs_pkg::POL_CSCAN, 17'd65536, 250);
    random_phase(drs_pkg::POL_CSCAN, 17'd1, 200);
    random_phase(drs_pkg::POL_CSCAN, 17'd300, 150);
    random_phase(2'd3, 17'($urandom_range(65536, 1)), 150);
    random_phase(drs_pkg::POL_SSTF, 17'd1, 150);
    random_phase(drs_pkg::POL_CSCAN, 17'($urandom_range(65535, 2)), 150);
  endtask

  initial begin
    pol_q = drs_pkg::POL_FCFS;
    disk_q = 17'd65536;
    pend_q = 0;
    head_q = '0;
    seek_q = '0;
    busy_q = 1'b0;
    busy_blk = '0;
    busy_tag = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    test_field_extremes();
    test_status_cases();
    empty_queue();
    test_backpressure();
    test_random_policies();
    empty_queue();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+sv
sv/drs_pkg.sv
sv/drs_stream_if.sv
sv/drs_front.sv
sv/drs_back.sv
sv/disk_request_scheduler_unit.sv
tb/disk_request_scheduler_unit_test.sv
